@@ hdl/nrte_pkg.sv @@
package nrte_pkg;

  localparam int unsigned LineCapacity = 128;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChDot    = 8'h2E;

  localparam logic [1:0] StShort = 2'd0;
  localparam logic [1:0] StCsum  = 2'd1;
  localparam logic [1:0] StSent  = 2'd2;
  localparam logic [1:0] StValid = 2'd3;

  localparam logic CfgMinLen = 1'b0;
  localparam logic CfgOffset = 1'b1;

  // Blank as the C library sees it: space, tab, LF, VT, FF, CR.
  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Hex digit value; bit 4 set marks a non-hex character.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

endpackage

@@ hdl/nmea_rmc_time_extractor_top.sv @@
// NMEA RMC time extractor.
// Slave stream: one transaction per received character with its timer count.
// '$' restarts the line, other characters (except newline) are stored in a
// line memory while it has room. A newline starts a scan of the stored line
// (none if it is shorter than min_line_length) and produces exactly one result
// transaction on the master stream: status, the UTC time pair values, the
// fraction times 1000, the zone offset and the newline's timer count.
// Throughput: ordinary characters are taken one per cycle. A newline starts a
// scan of the line memory, one byte read per cycle, through the zero search,
// checksum and hex field, comma search, header and time pairs, two passes over
// the fraction and the multiply; a short line gets its result without a scan.
// The scan holds off new input; a finished result sits in the output register
// and the block takes the next characters while it waits there, stalling only
// when a second newline arrives before the first result is taken.
// Reset clears the fill count, the scan control and the output valid, and
// loads min_line_length = 20 and local_offset_hours = 3. The line memory
// itself has no reset; only written entries are ever used.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 min_line_length, 1 local_offset_hours) at a clock edge.
module nmea_rmc_time_extractor_top #(
  parameter int unsigned LINE_CAPACITY = nrte_pkg::LineCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte, [39:8] timestamp
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [8:2] hours, [15:9] minutes, [22:16] seconds,
  // [54:23] sub_second_bias, [59:55] zone_offset, [91:60] line_timestamp, pad
  output logic [95:0] m_axis_tdata
);
  import nrte_pkg::*;

  localparam int unsigned AW = $clog2(LINE_CAPACITY);
  localparam int unsigned CW = $clog2(LINE_CAPACITY + 1);

  // Scan phases.
  localparam logic [3:0] PIdle  = 4'd0;
  localparam logic [3:0] PZero  = 4'd1;
  localparam logic [3:0] PStar  = 4'd2;
  localparam logic [3:0] PHex   = 4'd3;
  localparam logic [3:0] PComma = 4'd4;
  localparam logic [3:0] PHdr   = 4'd5;
  localparam logic [3:0] PDec   = 4'd6;
  localparam logic [3:0] PFracQ = 4'd7;
  localparam logic [3:0] PMul   = 4'd8;
  localparam logic [3:0] PDone  = 4'd9;

  logic [7:0] min_len_q;
  logic [4:0] offset_q;
  logic [CW-1:0] fill_q;

  logic [7:0] mem [LINE_CAPACITY];
  logic [7:0] rdata_q;

  logic [3:0]    ph_q;
  logic [CW:0]   pos_q;      // address of the byte in rdata_q
  logic          rv_q;       // rdata_q holds a byte requested last cycle
  logic [CW-1:0] tlen_q, comma_q;
  logic [7:0]    x_q, hex_q;
  logic [1:0]    sub_q;      // hex: 0 blanks,1 sign,2 prefix,3 digits
  logic          neg_q, zsaw_q, xsaw_q;
  logic [1:0]    fld_q;      // 0 hh,1 mm,2 ss,3 fraction
  logic [CW:0]   dend_q;
  logic [31:0]   dv_q, bias_q;
  logic [6:0]    hh_q, mm_q, ss_q;
  logic [31:0]   ts_q;
  logic          dflag_q;

  logic [95:0] out_q;
  logic        ov_q;

  logic [CW:0] rd_addr;
  logic        rd_en;
  logic [7:0]  c;
  logic        in_acc, out_acc;

  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (ph_q == PIdle) && !(ov_q && s_axis_tdata[7:0] == ChNl);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata = out_q;

  // Character seen at pos_q, reading zero past the text end.
  assign c = (rv_q && pos_q < {1'b0, tlen_q}) ? rdata_q : 8'h00;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= 8'd20;
      offset_q  <= 5'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinLen: min_len_q <= cfg_data_i;
        CfgOffset: offset_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Line memory: one write or one read per cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tdata[7:0] != ChDollar && s_axis_tdata[7:0] != ChNl
        && fill_q < CW'(LINE_CAPACITY))
      mem[fill_q[AW-1:0]] <= s_axis_tdata[7:0];
    if (rd_en) rdata_q <= mem[rd_addr[AW-1:0]];
  end

  // Scan sequencer: each phase reads consecutive addresses; rd_addr is the
  // next address, rdata arrives in the next cycle together with pos_q.
  logic [3:0]    ph_d;
  logic [CW:0]   pos_d;
  logic          rv_d;
  logic [CW-1:0] tlen_d, comma_d;
  logic [7:0]    x_d, hex_d;
  logic [1:0]    sub_d, fld_d, st;
  logic          neg_d, zsaw_d, xsaw_d, dflag_d;
  logic [CW:0]   dend_d;
  logic [31:0]   dv_d, bias_d;
  logic [6:0]    hh_d, mm_d, ss_d;
  logic          fin;
  logic [1:0]    fin_st;
  logic [4:0]    hv;
  logic [CW:0]   t0;

  assign hv = hex_val(c);
  assign t0 = {1'b0, comma_q} + 1'b1;

  always_comb begin
    ph_d = ph_q; pos_d = pos_q; rv_d = 1'b0;
    tlen_d = tlen_q; comma_d = comma_q;
    x_d = x_q; hex_d = hex_q; sub_d = sub_q; fld_d = fld_q;
    neg_d = neg_q; zsaw_d = zsaw_q; xsaw_d = xsaw_q; dflag_d = dflag_q;
    dend_d = dend_q; dv_d = dv_q; bias_d = bias_q;
    hh_d = hh_q; mm_d = mm_q; ss_d = ss_q;
    rd_en = 1'b0; rd_addr = pos_q + 1'b1;
    fin = 1'b0; fin_st = StShort;
    st = 2'd0;
    unique case (ph_q)
      PIdle: begin
        if (in_acc && s_axis_tdata[7:0] == ChNl) begin
          hh_d = '0; mm_d = '0; ss_d = '0; bias_d = '0;
          tlen_d = fill_q;
          if ({8'd0, fill_q} < {{CW{1'b0}}, min_len_q}) begin
            ph_d = PDone; fin_st = StShort;
            fin = 1'b1;
          end else begin
            ph_d = PZero; rd_en = 1'b1; rd_addr = '0; pos_d = '0; rv_d = 1'b1;
            tlen_d = fill_q; x_d = '0;
          end
        end
      end
      // Find the first zero byte; text ends there.
      PZero: begin
        if (pos_q >= {1'b0, fill_q}) begin
          ph_d = PStar; rd_en = 1'b1; rd_addr = '0; pos_d = '0; rv_d = 1'b1;
        end else if (rdata_q == 8'h00) begin
          tlen_d = pos_q[CW-1:0];
          ph_d = PStar; rd_en = 1'b1; rd_addr = '0; pos_d = '0; rv_d = 1'b1;
        end else begin
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end
      end
      // XOR up to the first '*'.
      PStar: begin
        if (pos_q >= {1'b0, tlen_q}) begin
          fin = 1'b1; fin_st = StCsum; ph_d = PDone;
        end else if (c == ChStar) begin
          ph_d = PHex; sub_d = 2'd0; neg_d = 1'b0; hex_d = '0;
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
          zsaw_d = 1'b0; xsaw_d = 1'b0;
        end else begin
          x_d = x_q ^ c;
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end
      end
      // Hex number after '*'; a "0x" prefix needs one byte of lookahead,
      // kept as zsaw (saw '0') and xsaw (saw '0x').
      PHex: begin
        st = 2'd0;
        if (sub_q == 2'd0 && is_blank(c)) begin
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end else if (sub_q == 2'd0 && (c == 8'h2B || c == 8'h2D)) begin
          neg_d = (c == 8'h2D); sub_d = 2'd1;
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end else if (sub_q <= 2'd1 && c == 8'h30 && !zsaw_q) begin
          zsaw_d = 1'b1; sub_d = 2'd2;
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end else if (sub_q == 2'd2 && !xsaw_q) begin
          if (c == 8'h78 || c == 8'h58) begin
            xsaw_d = 1'b1;
            rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
          end else begin
            // '0' was a plain digit.
            hex_d = 8'h00; sub_d = 2'd3;
            if (!hv[4]) begin
              hex_d = {4'h0, hv[3:0]};
              rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
            end else st = 2'd1;
          end
        end else if (sub_q == 2'd2 && xsaw_q) begin
          if (!hv[4]) begin
            hex_d = {4'h0, hv[3:0]}; sub_d = 2'd3;
            rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
          end else begin
            // No digit after 0x: value is the lone zero.
            hex_d = 8'h00; st = 2'd1;
          end
        end else if (!hv[4]) begin
          hex_d = {hex_q[3:0], hv[3:0]}; sub_d = 2'd3;
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end else st = 2'd1;
        if (st == 2'd1) begin
          if (x_q != (neg_q ? 8'(8'd0 - hex_d) : hex_d)) begin
            fin = 1'b1; fin_st = StCsum; ph_d = PDone;
          end else begin
            ph_d = PComma; rd_en = 1'b1; rd_addr = '0; pos_d = '0; rv_d = 1'b1;
          end
        end
      end
      // Find the first comma.
      PComma: begin
        if (pos_q >= {1'b0, tlen_q} || pos_q > (CW+1)'(5)) begin
          fin = 1'b1; fin_st = StSent; ph_d = PDone;
        end else if (c == ChComma) begin
          if (pos_q != (CW+1)'(5)) begin
            fin = 1'b1; fin_st = StSent; ph_d = PDone;
          end else begin
            comma_d = pos_q[CW-1:0];
            ph_d = PHdr; rd_en = 1'b1; rd_addr = '0; pos_d = '0; rv_d = 1'b1;
          end
        end else begin
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end
      end
      // Check "GPRMC" and that the time field is not empty.
      PHdr: begin
        logic [7:0] exp_c;
        exp_c = 8'h00;
        case (pos_q[2:0])
          3'd0: exp_c = 8'h47;
          3'd1: exp_c = 8'h50;
          3'd2: exp_c = 8'h52;
          3'd3: exp_c = 8'h4D;
          3'd4: exp_c = 8'h43;
          default: exp_c = 8'h00;
        endcase
        if (pos_q < (CW+1)'(5) && c != exp_c) begin
          fin = 1'b1; fin_st = StSent; ph_d = PDone;
        end else if (pos_q == (CW+1)'(6)) begin
          if (c == ChComma) begin
            fin = 1'b1; fin_st = StSent; ph_d = PDone;
          end else begin
            ph_d = PDec; fld_d = 2'd0; dend_d = t0 + 2'd2; dv_d = '0;
            sub_d = 2'd0; neg_d = 1'b0; dflag_d = 1'b0;
            rd_en = 1'b1; rd_addr = t0; pos_d = t0; rv_d = 1'b1;
          end
        end else begin
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end
      end
      // Decimal reader over [pos, dend): blanks, sign, digits.
      PDec: begin
        logic stop;
        logic [31:0] r;
        stop = 1'b0;
        if (pos_q >= dend_q) stop = 1'b1;
        else if (sub_q == 2'd0 && is_blank(c)) begin
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end else if (sub_q == 2'd0 && (c == 8'h2B || c == 8'h2D)) begin
          neg_d = (c == 8'h2D); sub_d = 2'd1;
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end else if (is_digit(c)) begin
          dv_d = 32'((dv_q << 3) + (dv_q << 1)) + {28'd0, c[3:0]}; sub_d = 2'd1;
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end else stop = 1'b1;
        r = neg_q ? 32'd0 - dv_q : dv_q;
        if (stop) begin
          dv_d = r;
          sub_d = 2'd0; neg_d = 1'b0;
          unique case (fld_q)
            2'd0: begin
              hh_d = r[6:0]; fld_d = 2'd1; dv_d = '0; dend_d = t0 + 3'd4;
              rd_en = 1'b1; rd_addr = t0 + 2'd2; pos_d = t0 + 2'd2; rv_d = 1'b1;
            end
            2'd1: begin
              mm_d = r[6:0]; fld_d = 2'd2; dv_d = '0; dend_d = t0 + 3'd6;
              rd_en = 1'b1; rd_addr = t0 + 3'd4; pos_d = t0 + 3'd4; rv_d = 1'b1;
            end
            2'd2: begin
              ss_d = r[6:0]; ph_d = PFracQ; dflag_d = 1'b0;
              rd_en = 1'b1; rd_addr = t0 + 3'd6; pos_d = t0 + 3'd6; rv_d = 1'b1;
            end
            default: begin
              ph_d = PMul;
            end
          endcase
        end
      end
      // Look for '.' then the closing comma of the fraction.
      PFracQ: begin
        if (!dflag_q) begin
          if (c == ChDot) begin
            dflag_d = 1'b1;
            rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
          end else begin
            fin = 1'b1; fin_st = StValid; ph_d = PDone;
          end
        end else if (pos_q >= {1'b0, tlen_q}) begin
          fin = 1'b1; fin_st = StValid; ph_d = PDone;
        end else if (c == ChComma) begin
          ph_d = PDec; fld_d = 2'd3; dv_d = '0; dend_d = pos_q;
          rd_en = 1'b1; rd_addr = t0 + 3'd7; pos_d = t0 + 3'd7; rv_d = 1'b1;
        end else begin
          rd_en = 1'b1; pos_d = pos_q + 1'b1; rv_d = 1'b1;
        end
      end
      // One multiply, registered, then done.
      PMul: begin
        bias_d = 32'(dv_q * 32'd1000);
        fin = 1'b1; fin_st = StValid; ph_d = PDone;
      end
      PDone: begin
        if (!ov_q) ph_d = PIdle;
      end
      default: ph_d = PIdle;
    endcase
  end

  logic [1:0] fst_q;
  logic       fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PIdle; rv_q <= 1'b0; fill_q <= '0; ov_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      ph_q <= ph_d; rv_q <= rv_d; fin_q <= fin;
      if (in_acc) begin
        if (s_axis_tdata[7:0] == ChDollar) fill_q <= '0;
        else if (s_axis_tdata[7:0] != ChNl && fill_q < CW'(LINE_CAPACITY))
          fill_q <= fill_q + 1'b1;
      end
      if (fin_q) ov_q <= 1'b1;
      else if (out_acc) ov_q <= 1'b0;
    end
  end

  // Scan datapath registers.
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; tlen_q <= tlen_d; comma_q <= comma_d;
    x_q <= x_d; hex_q <= hex_d; sub_q <= sub_d;
    fld_q <= fld_d; neg_q <= neg_d; xsaw_q <= xsaw_d; dflag_q <= dflag_d;
    zsaw_q <= zsaw_d; dend_q <= dend_d; dv_q <= dv_d; bias_q <= bias_d;
    hh_q <= hh_d; mm_q <= mm_d; ss_q <= ss_d; fst_q <= fin_st;
    if (in_acc && s_axis_tdata[7:0] == ChNl) ts_q <= s_axis_tdata[39:8];
    if (fin_q) begin
      out_q <= {4'd0, ts_q, offset_q,
                (fst_q == StValid) ? bias_q : 32'd0,
                (fst_q == StValid) ? ss_q : 7'd0,
                (fst_q == StValid) ? mm_q : 7'd0,
                (fst_q == StValid) ? hh_q : 7'd0, fst_q};
    end
  end

  // Checks.
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != PIdle) |-> !s_axis_tready) else $error("input taken during scan");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(LINE_CAPACITY)) else $error("fill count overflow");
  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (ph_q == PDone)) else $error("result outside done phase");
  a_ov_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready) |=> ov_q) else $error("result dropped");

endmodule
